[src/itp_pkg.sv]
// ----------------------------------------------------------------------------
// itp_pkg: shared definitions for the infix-to-postfix converter
// Token codes, stack sizing, the command passed from front to back, and the
// result beat layout.
// ----------------------------------------------------------------------------
package itp_pkg;

   localparam int STACK_DEPTH = 32;
   localparam int IDX_W       = $clog2(STACK_DEPTH);
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

   localparam int FUNC_W  = 3;
   localparam int OP_W    = 3;
   localparam int VALUE_W = 32;
   localparam int ERR_W   = 2;

   // Input token kinds.
   localparam logic [FUNC_W-1:0] FUNC_OPERAND = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_OPEN    = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_CLOSE   = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_OPER    = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_END     = 3'd4;

   // Operator codes; the stack also holds the paren mark.
   localparam logic [OP_W-1:0] OP_PLUS    = 3'd0;
   localparam logic [OP_W-1:0] OP_MINUS   = 3'd1;
   localparam logic [OP_W-1:0] OP_TIMES   = 3'd2;
   localparam logic [OP_W-1:0] OP_DIVIDE  = 3'd3;
   localparam logic [OP_W-1:0] OP_MODULO  = 3'd4;
   localparam logic [OP_W-1:0] PAREN_MARK = 3'd5;

   // Error codes of a result beat.
   localparam logic [ERR_W-1:0] ERR_NONE     = 2'd0;
   localparam logic [ERR_W-1:0] ERR_OVERFLOW = 2'd1;
   localparam logic [ERR_W-1:0] ERR_CLOSE    = 2'd2;
   localparam logic [ERR_W-1:0] ERR_OPEN     = 2'd3;

   localparam logic KIND_OPERAND_OUT  = 1'b0;
   localparam logic KIND_OPERATOR_OUT = 1'b1;

   typedef enum logic [2:0] {
      CMD_OPERAND,
      CMD_OPEN,
      CMD_CLOSE,
      CMD_OPER,
      CMD_END
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type       kind;
      logic [OP_W-1:0]    op;
      logic [VALUE_W-1:0] value;
   } cmd_type;

   typedef struct packed {
      logic               out_kind;
      logic [OP_W-1:0]    out_op;
      logic [VALUE_W-1:0] out_value;
      logic [ERR_W-1:0]   error_code;
      logic               last;
   } result_type;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   // Times, divide and modulo form the higher priority class.
   function automatic logic rank_hi(input logic [OP_W-1:0] op);
      rank_hi = (op == OP_TIMES) || (op == OP_DIVIDE) || (op == OP_MODULO);
   endfunction

endpackage

[src/itp_front.sv]
// ----------------------------------------------------------------------------
// itp_front: token intake and command queue
// Accepts input beats, drops tokens that mean nothing, and holds up to two
// classified commands for the back end.
// ----------------------------------------------------------------------------
module itp_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [itp_pkg::FUNC_W-1:0]    req_func,
   input  logic [itp_pkg::OP_W-1:0]      req_op_code,
   input  logic [itp_pkg::VALUE_W-1:0]   req_operand_value,
   output logic                          deq_valid,
   input  logic                          deq_ready,
   output itp_pkg::cmd_type              deq_cmd
);

   itp_pkg::cmd_type   cmd;
   logic               keep;
   logic               push;
   logic               pop;

   itp_pkg::cmd_type   entry_ff [2];
   logic               wr_ptr_ff;
   logic               wr_ptr_in;
   logic               rd_ptr_ff;
   logic               rd_ptr_in;
   logic [1:0]         fill_ff;
   logic [1:0]         fill_in;

   always_comb begin
      keep      = 1'b1;
      cmd.op    = req_op_code;
      cmd.value = req_operand_value;
      cmd.kind  = itp_pkg::CMD_OPERAND;
      unique case (req_func)
         itp_pkg::FUNC_OPERAND: cmd.kind = itp_pkg::CMD_OPERAND;
         itp_pkg::FUNC_OPEN:    cmd.kind = itp_pkg::CMD_OPEN;
         itp_pkg::FUNC_CLOSE:   cmd.kind = itp_pkg::CMD_CLOSE;
         itp_pkg::FUNC_OPER: begin
            cmd.kind = itp_pkg::CMD_OPER;
            keep     = (req_op_code <= itp_pkg::OP_MODULO);
         end
         itp_pkg::FUNC_END:     cmd.kind = itp_pkg::CMD_END;
         default:               keep = 1'b0;
      endcase
   end

   // An ignored token is still accepted; it just never enters the queue.
   assign req_ready = (fill_ff != 2'd2);
   assign push      = req_valid && req_ready && keep;
   assign deq_valid = (fill_ff != 2'd0);
   assign pop       = deq_valid && deq_ready;
   assign deq_cmd   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= cmd;
      end
   end

endmodule

[src/itp_back.sv]
// ----------------------------------------------------------------------------
// itp_back: operator stack engine
// Executes one command at a time against the operator stack, popping one
// entry per cycle unless a stalled result beat holds it, and drives the result register.
// ----------------------------------------------------------------------------
module itp_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          deq_valid,
   output logic                          deq_ready,
   input  itp_pkg::cmd_type              deq_cmd,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output itp_pkg::result_type           rsp_data
);

   itp_pkg::state_type           state_ff;
   itp_pkg::state_type           state_in;
   itp_pkg::cmd_type             cmd_ff;
   logic [itp_pkg::CNT_W-1:0]    cnt_ff;
   logic [itp_pkg::CNT_W-1:0]    cnt_in;
   logic [itp_pkg::CNT_W-1:0]    par_ff;
   logic [itp_pkg::CNT_W-1:0]    par_in;
   logic                         err_open_ff;
   logic                         err_open_in;
   logic [itp_pkg::OP_W-1:0]     top_ff;
   logic [itp_pkg::OP_W-1:0]     stack_ff [itp_pkg::STACK_DEPTH];
   itp_pkg::result_type          rsp_ff;
   logic                         rsp_valid_ff;

   // The top entry lives in top_ff; the array holds the entries below it.
   logic [itp_pkg::IDX_W-1:0]    idx_next;
   logic [itp_pkg::IDX_W-1:0]    idx_push;
   logic [itp_pkg::OP_W-1:0]     nxt;
   logic                         empty;
   logic                         full;
   logic                         more;
   logic                         top_paren;
   logic                         out_free;
   logic                         act;

   logic                         emit;
   itp_pkg::result_type          res;
   logic                         do_pop;
   logic                         do_push;
   logic [itp_pkg::OP_W-1:0]     push_val;
   logic                         done;
   logic                         set_err;

   assign idx_next  = itp_pkg::IDX_W'(cnt_ff - itp_pkg::CNT_W'(2));
   assign idx_push  = itp_pkg::IDX_W'(cnt_ff - itp_pkg::CNT_W'(1));
   assign nxt       = stack_ff[idx_next];
   assign empty     = (cnt_ff == '0);
   assign full      = (cnt_ff >= itp_pkg::CNT_W'(itp_pkg::STACK_DEPTH));
   assign more      = (cnt_ff >= itp_pkg::CNT_W'(2));
   assign top_paren = (top_ff == itp_pkg::PAREN_MARK);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         itp_pkg::ST_IDLE: if (deq_valid) state_in = itp_pkg::ST_RUN;
         itp_pkg::ST_RUN:  if (act && done) state_in = itp_pkg::ST_IDLE;
         default:          state_in = itp_pkg::ST_IDLE;
      endcase
   end

   // Per-cycle action of the running command. The last flag is decided from the
   // entry below the top, or for an end from the stack counts, with no step of its own.
   always_comb begin
      emit           = 1'b0;
      res            = '0;
      do_pop         = 1'b0;
      do_push        = 1'b0;
      push_val       = cmd_ff.op;
      done           = 1'b0;
      set_err        = 1'b0;
      unique case (cmd_ff.kind)
         itp_pkg::CMD_OPERAND: begin
            emit          = 1'b1;
            res.out_value = cmd_ff.value;
            res.last      = 1'b1;
            done          = 1'b1;
         end
         itp_pkg::CMD_OPEN: begin
            done = 1'b1;
            if (full) begin
               emit           = 1'b1;
               res.error_code = itp_pkg::ERR_OVERFLOW;
               res.last       = 1'b1;
            end else begin
               do_push  = 1'b1;
               push_val = itp_pkg::PAREN_MARK;
            end
         end
         itp_pkg::CMD_CLOSE: begin
            if (empty) begin
               emit           = 1'b1;
               res.error_code = itp_pkg::ERR_CLOSE;
               res.last       = 1'b1;
               done           = 1'b1;
            end else if (top_paren) begin
               do_pop = 1'b1;
               done   = 1'b1;
            end else begin
               emit         = 1'b1;
               res.out_kind = itp_pkg::KIND_OPERATOR_OUT;
               res.out_op   = top_ff;
               res.last     = more && (nxt == itp_pkg::PAREN_MARK);
               do_pop       = 1'b1;
            end
         end
         itp_pkg::CMD_OPER: begin
            if (!empty && !top_paren &&
                (itp_pkg::rank_hi(top_ff) || !itp_pkg::rank_hi(cmd_ff.op))) begin
               emit         = 1'b1;
               res.out_kind = itp_pkg::KIND_OPERATOR_OUT;
               res.out_op   = top_ff;
               res.last     = !more || (nxt == itp_pkg::PAREN_MARK) ||
                              (itp_pkg::rank_hi(cmd_ff.op) && !itp_pkg::rank_hi(nxt));
               do_pop       = 1'b1;
            end else if (full) begin
               emit           = 1'b1;
               res.error_code = itp_pkg::ERR_OVERFLOW;
               res.last       = 1'b1;
               done           = 1'b1;
            end else begin
               do_push = 1'b1;
               done    = 1'b1;
            end
         end
         itp_pkg::CMD_END: begin
            if (empty) begin
               done = 1'b1;
               if (err_open_ff) begin
                  emit           = 1'b1;
                  res.error_code = itp_pkg::ERR_OPEN;
                  res.last       = 1'b1;
               end
            end else if (top_paren) begin
               do_pop  = 1'b1;
               set_err = 1'b1;
            end else begin
               emit         = 1'b1;
               res.out_kind = itp_pkg::KIND_OPERATOR_OUT;
               res.out_op   = top_ff;
               res.last     = ((cnt_ff - par_ff) == itp_pkg::CNT_W'(1)) &&
                              (par_ff == '0) && !err_open_ff;
               do_pop       = 1'b1;
            end
         end
         default: done = 1'b1;
      endcase
   end

   assign act       = (state_ff == itp_pkg::ST_RUN) && (!emit || out_free);
   assign deq_ready = (state_ff == itp_pkg::ST_IDLE);

   always_comb begin
      cnt_in      = cnt_ff;
      par_in      = par_ff;
      err_open_in = err_open_ff;
      if (state_ff == itp_pkg::ST_IDLE) begin
         err_open_in = 1'b0;
      end else if (act) begin
         if (do_push) begin
            cnt_in = cnt_ff + itp_pkg::CNT_W'(1);
            if (push_val == itp_pkg::PAREN_MARK) par_in = par_ff + itp_pkg::CNT_W'(1);
         end else if (do_pop) begin
            cnt_in = cnt_ff - itp_pkg::CNT_W'(1);
            if (top_paren) par_in = par_ff - itp_pkg::CNT_W'(1);
         end
         if (set_err) err_open_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= itp_pkg::ST_IDLE;
         cnt_ff       <= '0;
         par_ff       <= '0;
         err_open_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         cnt_ff      <= cnt_in;
         par_ff      <= par_in;
         err_open_ff <= err_open_in;
         if (act && emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == itp_pkg::ST_IDLE && deq_valid) begin
         cmd_ff <= deq_cmd;
      end
      if (act && emit) begin
         rsp_ff <= res;
      end
      if (act && do_push) begin
         if (!empty) stack_ff[idx_push] <= top_ff;
         top_ff <= push_val;
      end else if (act && do_pop) begin
         top_ff <= nxt;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[src/infix_to_postfix_converter.sv]
// ----------------------------------------------------------------------------
// infix_to_postfix_converter: shunting-yard infix to postfix conversion
//
//   channel  direction  handshake              beat
//   req_     in         req_valid / req_ready  func, op_code, operand_value
//   rsp_     out        rsp_valid / rsp_ready  out_kind, out_op, out_value,
//                                              error_code, last
//
// The back end fetches a command, then makes one result or stack move per cycle
// while no stalled result beat holds it, as the single stack port allows: an
// operand or open paren ends in the step after the fetch, an operator or end takes
// a step per entry popped plus a final step, a close one per operator plus its paren.
// Ignored tokens never reach the back end.
// A two-beat queue lets the intake keep accepting while the back end works.
// A stalled result beat holds the back end; reset empties queue and stack.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [itp_pkg::FUNC_W-1:0]    req_func,
   input  logic [itp_pkg::OP_W-1:0]      req_op_code,
   input  logic [itp_pkg::VALUE_W-1:0]   req_operand_value,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_out_kind,
   output logic [itp_pkg::OP_W-1:0]      rsp_out_op,
   output logic [itp_pkg::VALUE_W-1:0]   rsp_out_value,
   output logic [itp_pkg::ERR_W-1:0]     rsp_error_code,
   output logic                          rsp_last
);

   logic                  deq_valid;
   logic                  deq_ready;
   itp_pkg::cmd_type      deq_cmd;
   itp_pkg::result_type   rsp_data;

   itp_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_func          (req_func),
      .req_op_code       (req_op_code),
      .req_operand_value (req_operand_value),
      .deq_valid         (deq_valid),
      .deq_ready         (deq_ready),
      .deq_cmd           (deq_cmd)
   );

   itp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .deq_valid (deq_valid),
      .deq_ready (deq_ready),
      .deq_cmd   (deq_cmd),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_out_kind   = rsp_data.out_kind;
   assign rsp_out_op     = rsp_data.out_op;
   assign rsp_out_value  = rsp_data.out_value;
   assign rsp_error_code = rsp_data.error_code;
   assign rsp_last       = rsp_data.last;

endmodule

[src/itp_checker.sv]
// ----------------------------------------------------------------------------
// itp_checker: port-level checks for the infix-to-postfix converter
// Watches the result channel for beat-format and stall rules.
// ----------------------------------------------------------------------------
module itp_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic                          rsp_out_kind,
   input  logic [itp_pkg::OP_W-1:0]      rsp_out_op,
   input  logic [itp_pkg::VALUE_W-1:0]   rsp_out_value,
   input  logic [itp_pkg::ERR_W-1:0]     rsp_error_code,
   input  logic                          rsp_last
);

   // A stalled result beat holds its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_kind) &&
      $stable(rsp_out_op) && $stable(rsp_out_value) &&
      $stable(rsp_error_code) && $stable(rsp_last))
      else $error("result beat changed while stalled");

   // Every error ends the results of its token.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_error_code != itp_pkg::ERR_NONE) |->
      rsp_last && (rsp_out_kind == itp_pkg::KIND_OPERAND_OUT) && (rsp_out_value == '0))
      else $error("error beat is malformed");

   // Operator beats carry a real operator code and no value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_kind |->
      (rsp_error_code == itp_pkg::ERR_NONE) && (rsp_out_value == '0) &&
      (rsp_out_op <= itp_pkg::OP_MODULO))
      else $error("operator beat is malformed");

   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind infix_to_postfix_converter itp_checker u_itp_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_out_kind   (rsp_out_kind),
   .rsp_out_op     (rsp_out_op),
   .rsp_out_value  (rsp_out_value),
   .rsp_error_code (rsp_error_code),
   .rsp_last       (rsp_last)
);

[bench/itp_postfix_checker.sv]
// ----------------------------------------------------------------------------
// itp_postfix_checker: result checker for the infix-to-postfix converter
// Watches both channels, keeps its own operator stack to work out the
// postfix beats that each accepted token must cause, and compares every
// result beat field by field against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module itp_postfix_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic [itp_pkg::FUNC_W-1:0]    req_func,
   input  logic [itp_pkg::OP_W-1:0]      req_op_code,
   input  logic [itp_pkg::VALUE_W-1:0]   req_operand_value,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic                          rsp_out_kind,
   input  logic [itp_pkg::OP_W-1:0]      rsp_out_op,
   input  logic [itp_pkg::VALUE_W-1:0]   rsp_out_value,
   input  logic [itp_pkg::ERR_W-1:0]     rsp_error_code,
   input  logic                          rsp_last,
   output int                            fail_count,
   output int                            expected_left
);

   localparam int DUE_DEPTH = 1024;

   logic [itp_pkg::OP_W-1:0] pending_ops [itp_pkg::STACK_DEPTH];
   int                       ops_held;
   itp_pkg::result_type      postfix_due [DUE_DEPTH];
   int                       due_head;
   int                       due_tail;
   itp_pkg::result_type      held_beat;
   logic                     beat_held;
   int                       beats_seen;

   function automatic int priority_of(input logic [itp_pkg::OP_W-1:0] code);
      if (code == itp_pkg::OP_PLUS || code == itp_pkg::OP_MINUS) return 1;
      return 2;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("beat %0d: %s got 0x%0h want 0x%0h", beats_seen, what, got, want);
      fail_count++;
   endtask

   task automatic queue_beat(input itp_pkg::result_type beat);
      postfix_due[due_tail % DUE_DEPTH] = beat;
      due_tail++;
   endtask

   // The beat before is queued only once the next one exists, so the final
   // beat of a token can still be marked as last.
   task automatic emit_postfix(input logic kind, input logic [itp_pkg::OP_W-1:0] code,
                               input logic [itp_pkg::VALUE_W-1:0] value,
                               input logic [itp_pkg::ERR_W-1:0] err);
      if (beat_held) queue_beat(held_beat);
      held_beat.out_kind   = kind;
      held_beat.out_op     = code;
      held_beat.out_value  = value;
      held_beat.error_code = err;
      held_beat.last       = 1'b0;
      beat_held = 1'b1;
   endtask

   task automatic convert_token(input logic [itp_pkg::FUNC_W-1:0] func,
                                input logic [itp_pkg::OP_W-1:0] code,
                                input logic [itp_pkg::VALUE_W-1:0] value);
      logic [itp_pkg::OP_W-1:0] top_code;
      logic                     paren_found;
      paren_found = 1'b0;
      beat_held   = 1'b0;
      case (func)
         itp_pkg::FUNC_OPERAND:
            emit_postfix(itp_pkg::KIND_OPERAND_OUT, '0, value, itp_pkg::ERR_NONE);
         itp_pkg::FUNC_OPEN: begin
            if (ops_held >= itp_pkg::STACK_DEPTH) begin
               emit_postfix(itp_pkg::KIND_OPERAND_OUT, '0, '0, itp_pkg::ERR_OVERFLOW);
            end else begin
               pending_ops[ops_held] = itp_pkg::PAREN_MARK;
               ops_held++;
            end
         end
         itp_pkg::FUNC_CLOSE: begin
            while (ops_held > 0 && !paren_found) begin
               ops_held--;
               top_code = pending_ops[ops_held];
               if (top_code == itp_pkg::PAREN_MARK) paren_found = 1'b1;
               else emit_postfix(itp_pkg::KIND_OPERATOR_OUT, top_code, '0,
                                 itp_pkg::ERR_NONE);
            end
            if (!paren_found)
               emit_postfix(itp_pkg::KIND_OPERAND_OUT, '0, '0, itp_pkg::ERR_CLOSE);
         end
         itp_pkg::FUNC_OPER: begin
            if (code <= itp_pkg::OP_MODULO) begin
               while (ops_held > 0 && pending_ops[ops_held-1] != itp_pkg::PAREN_MARK &&
                      priority_of(pending_ops[ops_held-1]) >= priority_of(code)) begin
                  ops_held--;
                  emit_postfix(itp_pkg::KIND_OPERATOR_OUT, pending_ops[ops_held], '0,
                               itp_pkg::ERR_NONE);
               end
               if (ops_held >= itp_pkg::STACK_DEPTH) begin
                  emit_postfix(itp_pkg::KIND_OPERAND_OUT, '0, '0, itp_pkg::ERR_OVERFLOW);
               end else begin
                  pending_ops[ops_held] = code;
                  ops_held++;
               end
            end
         end
         itp_pkg::FUNC_END: begin
            while (ops_held > 0) begin
               ops_held--;
               top_code = pending_ops[ops_held];
               if (top_code == itp_pkg::PAREN_MARK) paren_found = 1'b1;
               else emit_postfix(itp_pkg::KIND_OPERATOR_OUT, top_code, '0,
                                 itp_pkg::ERR_NONE);
            end
            if (paren_found)
               emit_postfix(itp_pkg::KIND_OPERAND_OUT, '0, '0, itp_pkg::ERR_OPEN);
         end
         default: ;
      endcase
      if (beat_held) begin
         held_beat.last = 1'b1;
         queue_beat(held_beat);
      end
   endtask

   task automatic check_beat();
      itp_pkg::result_type want;
      if (due_head == due_tail) begin
         report_mismatch("unexpected beat, value", rsp_out_value, '0);
         return;
      end
      want = postfix_due[due_head % DUE_DEPTH];
      due_head++;
      if (rsp_out_kind !== want.out_kind)
         report_mismatch("out_kind", 32'(rsp_out_kind), 32'(want.out_kind));
      if (rsp_out_op !== want.out_op)
         report_mismatch("out_op", 32'(rsp_out_op), 32'(want.out_op));
      if (rsp_out_value !== want.out_value)
         report_mismatch("out_value", rsp_out_value, want.out_value);
      if (rsp_error_code !== want.error_code)
         report_mismatch("error_code", 32'(rsp_error_code), 32'(want.error_code));
      if (rsp_last !== want.last)
         report_mismatch("last", 32'(rsp_last), 32'(want.last));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         ops_held   = 0;
         fail_count = 0;
         beats_seen = 0;
         due_head   = 0;
         due_tail   = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            check_beat();
            beats_seen++;
         end
         if (req_valid && req_ready)
            convert_token(req_func, req_op_code, req_operand_value);
      end
      expected_left = due_tail - due_head;
   end

endmodule

[bench/infix_to_postfix_converter_tb.sv]
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_tb: testbench top for the infix-to-postfix converter
// Drives directed token streams, then random well-formed expressions, deep
// nests that run the operator stack past full, and broken token noise, with
// bursty input and a stalling receiver. The checker does the comparison.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter_tb;

   localparam int ITEM_TARGET    = 480;
   localparam int HOLD_CYCLES    = 300;
   localparam int DRAIN_CYCLES   = 120;
   localparam int WATCHDOG_LIMIT = 5000;

   // Codes outside the defined sets, used to check that such tokens are dropped.
   localparam logic [itp_pkg::OP_W-1:0]   OP_UNKNOWN   = 3'd7;
   localparam logic [itp_pkg::FUNC_W-1:0] FUNC_UNKNOWN = 3'd6;

   logic                          clock = 1'b0;
   logic                          reset;
   logic                          req_valid;
   logic                          req_ready;
   logic [itp_pkg::FUNC_W-1:0]    req_func;
   logic [itp_pkg::OP_W-1:0]      req_op_code;
   logic [itp_pkg::VALUE_W-1:0]   req_operand_value;
   logic                          rsp_valid;
   logic                          rsp_ready;
   logic                          rsp_out_kind;
   logic [itp_pkg::OP_W-1:0]      rsp_out_op;
   logic [itp_pkg::VALUE_W-1:0]   rsp_out_value;
   logic [itp_pkg::ERR_W-1:0]     rsp_error_code;
   logic                          rsp_last;

   int   fail_count;
   int   expected_left;
   int   items_sent;
   int   burst_left;
   int   quiet_cycles;
   logic stall_request;

   infix_to_postfix_converter dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_func          (req_func),
      .req_op_code       (req_op_code),
      .req_operand_value (req_operand_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_kind      (rsp_out_kind),
      .rsp_out_op        (rsp_out_op),
      .rsp_out_value     (rsp_out_value),
      .rsp_error_code    (rsp_error_code),
      .rsp_last          (rsp_last)
   );

   itp_postfix_checker check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_func          (req_func),
      .req_op_code       (req_op_code),
      .req_operand_value (req_operand_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_kind      (rsp_out_kind),
      .rsp_out_op        (rsp_out_op),
      .rsp_out_value     (rsp_out_value),
      .rsp_error_code    (rsp_error_code),
      .rsp_last          (rsp_last),
      .fail_count        (fail_count),
      .expected_left     (expected_left)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("infix_to_postfix_converter: mismatch");
         $finish;
      end
   end

   // Receiver: a stall pattern that is picked anew at random, plus one
   // long hold-off so the block backs up and stalls its input.
   initial begin
      int   mode;
      int   mode_left;
      int   hold_left;
      logic hold_taken;
      rsp_ready  = 1'b0;
      mode       = 0;
      mode_left  = 0;
      hold_left  = 0;
      hold_taken = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_request && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES;
         end
         if (mode_left == 0) begin
            mode      = $urandom_range(0, 3);
            mode_left = $urandom_range(20, 80);
         end
         mode_left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready = 1'b0;
         end else begin
            case (mode)
               0: rsp_ready = 1'b1;
               1: rsp_ready = 1'($urandom_range(0, 1));
               2: rsp_ready = (mode_left % 4 == 0);
               default: rsp_ready = ($urandom_range(0, 9) < 8);
            endcase
         end
      end
   end

   function automatic logic [itp_pkg::VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return $urandom();
      endcase
   endfunction

   // Called at a falling edge; returns at the falling edge after the beat.
   task automatic send_token(input logic [itp_pkg::FUNC_W-1:0] func,
                             input logic [itp_pkg::OP_W-1:0] code,
                             input logic [itp_pkg::VALUE_W-1:0] value);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         if (gap > 0) begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 12);
      end
      req_func          = func;
      req_op_code       = code;
      req_operand_value = value;
      req_valid         = 1'b1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      burst_left--;
      items_sent++;
   endtask

   task automatic send_operand(input logic [itp_pkg::VALUE_W-1:0] value);
      send_token(itp_pkg::FUNC_OPERAND, itp_pkg::OP_W'($urandom_range(0, 7)), value);
   endtask

   task automatic send_operator(input logic [itp_pkg::OP_W-1:0] code);
      send_token(itp_pkg::FUNC_OPER, code, $urandom());
   endtask

   task automatic send_marker(input logic [itp_pkg::FUNC_W-1:0] func);
      send_token(func, itp_pkg::OP_W'($urandom_range(0, 7)), $urandom());
   endtask

   task automatic send_expression(input int depth);
      int pick;
      pick = (depth >= 4) ? 0 : $urandom_range(0, 5);
      if (pick <= 1) begin
         send_operand(pick_value());
      end else if (pick == 2) begin
         send_marker(itp_pkg::FUNC_OPEN);
         send_expression(depth + 1);
         send_marker(itp_pkg::FUNC_CLOSE);
      end else begin
         send_expression(depth + 1);
         send_operator(itp_pkg::OP_W'($urandom_range(0, 4)));
         send_expression(depth + 1);
      end
   endtask

   // A nest of opens around the stack limit, a short operator chain inside
   // it, then a random number of closes that may miss or overshoot the opens.
   task automatic send_deep_nest(input int opens);
      int chain;
      int closes;
      chain  = $urandom_range(1, 4);
      closes = $urandom_range(0, opens + 1);
      repeat (opens) send_marker(itp_pkg::FUNC_OPEN);
      repeat (chain) begin
         send_operand(pick_value());
         send_operator(itp_pkg::OP_W'($urandom_range(0, 4)));
      end
      send_operand(pick_value());
      repeat (closes) send_marker(itp_pkg::FUNC_CLOSE);
      send_marker(itp_pkg::FUNC_END);
   endtask

   task automatic send_noise();
      int count;
      count = $urandom_range(1, 12);
      repeat (count)
         send_token(itp_pkg::FUNC_W'($urandom_range(0, 7)),
                    itp_pkg::OP_W'($urandom_range(0, 7)), $urandom());
      if ($urandom_range(0, 1)) send_marker(itp_pkg::FUNC_END);
   endtask

   initial begin
      int seq_index;
      int pick;
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_func          = '0;
      req_op_code       = '0;
      req_operand_value = '0;
      stall_request     = 1'b0;
      items_sent        = 0;
      burst_left        = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Operand extremes and a flush of an empty stack.
      send_operand('0);
      send_operand('1);
      send_marker(itp_pkg::FUNC_END);
      // a + (b * c - d) / e % f, touching every operator and both priorities.
      send_operand(32'd11);
      send_operator(itp_pkg::OP_PLUS);
      send_marker(itp_pkg::FUNC_OPEN);
      send_operand(32'd22);
      send_operator(itp_pkg::OP_TIMES);
      send_operand(32'd33);
      send_operator(itp_pkg::OP_MINUS);
      send_operand(32'd44);
      send_marker(itp_pkg::FUNC_CLOSE);
      send_operator(itp_pkg::OP_DIVIDE);
      send_operand(32'd55);
      send_operator(itp_pkg::OP_MODULO);
      send_operand(32'd66);
      send_marker(itp_pkg::FUNC_END);
      // A close with no open left: pops the operator, then reports it.
      send_operator(itp_pkg::OP_MINUS);
      send_marker(itp_pkg::FUNC_CLOSE);
      // End with opens still stacked.
      send_marker(itp_pkg::FUNC_OPEN);
      send_marker(itp_pkg::FUNC_OPEN);
      send_operator(itp_pkg::OP_MINUS);
      send_marker(itp_pkg::FUNC_END);
      // Unknown operator and unknown token kind are dropped.
      send_operator(OP_UNKNOWN);
      send_token(FUNC_UNKNOWN, itp_pkg::OP_W'($urandom_range(0, 7)), $urandom());

      stall_request = 1'b1;
      seq_index     = 0;
      while (items_sent < ITEM_TARGET) begin
         pick = $urandom_range(0, 99);
         if (seq_index == 0)
            send_deep_nest(itp_pkg::STACK_DEPTH + 1);
         else if (pick < 10)
            send_deep_nest($urandom_range(itp_pkg::STACK_DEPTH - 3,
                                          itp_pkg::STACK_DEPTH + 2));
         else if (pick < 75) begin
            send_expression(0);
            send_marker(itp_pkg::FUNC_END);
         end else
            send_noise();
         seq_index++;
      end
      req_valid = 1'b0;

      wait (expected_left == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && expected_left == 0)
         $display("infix_to_postfix_converter: match");
      else
         $display("infix_to_postfix_converter: mismatch");
      $finish;
   end

endmodule
